// File: rtl/mts_pkg.sv
// mts_pkg: shared types and constants for the melody tone sequencer
// command codes, tone update codes, field widths and stream packing widths
// no dependencies
package mts_pkg;

  localparam int MELODY_SLOTS_DEF     = 8;
  localparam int NOTES_PER_MELODY_DEF = 8;

  localparam int MEL_W  = 3;
  localparam int NOTE_W = 3;
  localparam int FREQ_W = 16;
  localparam int DUR_W  = 16;
  localparam int LEN_W  = 4;
  localparam int WORD_W = FREQ_W + DUR_W;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_PLAY = 2'd1,
    CMD_STOP = 2'd2,
    CMD_LOAD = 2'd3
  } cmd_t;

  // what the tone register does once the new note position is known
  typedef enum logic [1:0] {
    TONE_KEEP = 2'd0,
    TONE_ZERO = 2'd1,
    TONE_NOTE = 2'd2
  } tone_act_t;

endpackage

// File: rtl/melody_tone_sequencer.sv
// melody_tone_sequencer: plays stored melodies out of a note store
// result appears on out_tvalid once its request has passed the execute stage
// (from the input register), the tone stage and the tone fetch into the output register
// sustains one request per cycle while out_tready does not stall the output; the note store port is read every cycle
// reset clears melody lengths, player state and mute; the note store is not
// cleared and needs no clearing pass, so requests are taken right after reset
module melody_tone_sequencer #(
  parameter int MELODY_SLOTS     = mts_pkg::MELODY_SLOTS_DEF,
  parameter int NOTES_PER_MELODY = mts_pkg::NOTES_PER_MELODY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,   // mute
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // melody_id[2:0], note_index[5:3], note_freq[21:6], note_dur[37:22],
  // repeat_req[38], zero fill
  input  logic [mts_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [1:0]                       in_tuser,    // cmd
  input  logic                             in_tlast,    // note_last
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tone_freq[15:0], playing[16], note_pos[19:17], zero fill
  output logic [mts_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int DEPTH     = MELODY_SLOTS * NOTES_PER_MELODY;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MEL_SPAN  = 1 << mts_pkg::MEL_W;
  localparam int LEN_DEPTH = (MELODY_SLOTS < MEL_SPAN) ? MELODY_SLOTS : MEL_SPAN;
  localparam int LEN_IW    = (LEN_DEPTH > 1) ? $clog2(LEN_DEPTH) : 1;

  localparam int FW = mts_pkg::FREQ_W;
  localparam int DW = mts_pkg::DUR_W;
  localparam int MW = mts_pkg::MEL_W;
  localparam int NW = mts_pkg::NOTE_W;
  localparam int LW = mts_pkg::LEN_W;
  localparam int WW = mts_pkg::WORD_W;

  // configuration
  logic mute_r;

  // execute stage (input register)
  logic                 e_v_r;
  mts_pkg::cmd_t        e_cmd_r;
  logic [MW-1:0]        e_mel_r;
  logic [NW-1:0]        e_idx_r;
  logic [FW-1:0]        e_freq_r;
  logic [DW-1:0]        e_dur_r;
  logic                 e_last_r;
  logic                 e_rep_r;

  // player state
  logic [MW-1:0]        cur_mel_r, cur_mel_nxt;
  logic [NW-1:0]        note_r, note_nxt;
  logic [DW-1:0]        elapsed_r, elapsed_nxt;
  logic                 playing_r, playing_nxt;
  logic                 rep_r, rep_nxt;
  logic [LW-1:0]        cur_len_r, cur_len_nxt;
  logic [LW-1:0]        len_r [LEN_DEPTH];
  logic [FW-1:0]        tone_r;

  // tone stage
  logic                 p_v_r;
  mts_pkg::tone_act_t   p_act_r;
  mts_pkg::tone_act_t   act_nxt;
  logic                 p_playing_r;
  logic [NW-1:0]        p_note_r;

  // output register
  logic                 o_v_r;
  logic [FW-1:0]        o_tone_r;
  logic                 o_play_r;
  logic [NW-1:0]        o_note_r;

  // note store
  logic [WW-1:0]        mem [DEPTH];
  logic [WW-1:0]        rd_q_r;
  logic                 byp_hit_r;
  logic [WW-1:0]        byp_data_r;
  logic [WW-1:0]        cur_word;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 mem_we, len_we;

  logic                 e_adv, p_adv, exec;
  logic                 mel_ok, idx_ok, wrap, ignore;
  logic [LW-1:0]        play_len;
  logic [LW-1:0]        next_note;
  logic [LW-1:0]        load_len;
  logic [DW-1:0]        el_inc;
  logic [FW-1:0]        tone_sel;

  assign p_adv     = !o_v_r || out_tready;
  assign e_adv     = !p_v_r || p_adv;
  assign in_tready = !e_v_r || e_adv;
  assign exec      = e_v_r && e_adv;

  assign out_tvalid = o_v_r;
  assign out_tdata  = {{(mts_pkg::OUT_TDATA_W - FW - 1 - NW){1'b0}},
                       o_note_r, o_play_r, o_tone_r};

  // word at the current position as the store holds it right now
  assign cur_word = byp_hit_r ? byp_data_r : rd_q_r;

  assign mel_ok   = 32'(e_mel_r) < MELODY_SLOTS;
  assign idx_ok   = 32'(e_idx_r) < NOTES_PER_MELODY;
  assign play_len = mel_ok ? len_r[e_mel_r[LEN_IW-1:0]] : '0;
  assign load_len = {1'b0, e_idx_r} + LW'(1);
  assign el_inc   = (elapsed_r == '1) ? elapsed_r : elapsed_r + DW'(1);
  assign next_note = {1'b0, note_r} + LW'(1);
  assign wrap     = (next_note >= cur_len_r) || (32'(next_note) >= NOTES_PER_MELODY);
  assign ignore   = (mute_r && !e_rep_r)
                 || (playing_r && play_len == LW'(1) && cur_len_r > LW'(1) && !e_rep_r)
                 || (play_len == '0);

  assign wr_addr = AW'(32'(e_mel_r) * NOTES_PER_MELODY + 32'(e_idx_r));
  assign rd_addr = AW'(32'(cur_mel_nxt) * NOTES_PER_MELODY + 32'(note_nxt));

  always_comb begin
    cur_mel_nxt = cur_mel_r;
    note_nxt    = note_r;
    elapsed_nxt = elapsed_r;
    playing_nxt = playing_r;
    rep_nxt     = rep_r;
    cur_len_nxt = cur_len_r;
    act_nxt     = mts_pkg::TONE_KEEP;
    mem_we      = 1'b0;
    len_we      = 1'b0;
    if (exec) begin
      case (e_cmd_r)
        mts_pkg::CMD_TICK: begin
          if (playing_r) begin
            if (el_inc < cur_word[DW-1:0]) begin
              elapsed_nxt = el_inc;
            end else if (wrap && !rep_r) begin
              elapsed_nxt = el_inc;
              playing_nxt = 1'b0;
              act_nxt     = mts_pkg::TONE_ZERO;
            end else begin
              note_nxt    = wrap ? '0 : next_note[NW-1:0];
              elapsed_nxt = '0;
              act_nxt     = mts_pkg::TONE_NOTE;
            end
          end
        end
        mts_pkg::CMD_PLAY: begin
          if (!ignore) begin
            cur_mel_nxt = e_mel_r;
            note_nxt    = '0;
            elapsed_nxt = '0;
            playing_nxt = 1'b1;
            rep_nxt     = e_rep_r;
            cur_len_nxt = play_len;
            act_nxt     = mts_pkg::TONE_NOTE;
          end
        end
        mts_pkg::CMD_STOP: begin
          playing_nxt = 1'b0;
          rep_nxt     = 1'b0;
          act_nxt     = mts_pkg::TONE_ZERO;
        end
        mts_pkg::CMD_LOAD: begin
          if (mel_ok && idx_ok) begin
            mem_we = 1'b1;
            if (e_last_r) begin
              len_we = 1'b1;
              // keep the cached length of the current melody in step
              if (e_mel_r == cur_mel_r) cur_len_nxt = load_len;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (p_act_r)
      mts_pkg::TONE_NOTE: tone_sel = cur_word[WW-1:DW];
      mts_pkg::TONE_ZERO: tone_sel = '0;
      default:            tone_sel = tone_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_r    <= 1'b0;
      e_v_r     <= 1'b0;
      p_v_r     <= 1'b0;
      o_v_r     <= 1'b0;
      cur_mel_r <= '0;
      note_r    <= '0;
      elapsed_r <= '0;
      playing_r <= 1'b0;
      rep_r     <= 1'b0;
      cur_len_r <= '0;
      tone_r    <= '0;
      byp_hit_r <= 1'b0;
      for (int i = 0; i < LEN_DEPTH; i++) len_r[i] <= '0;
    end else begin
      if (cfg_we) mute_r <= cfg_wdata;
      if (in_tready) e_v_r <= in_tvalid;
      if (e_adv) p_v_r <= e_v_r;
      if (p_adv) o_v_r <= p_v_r;
      cur_mel_r <= cur_mel_nxt;
      note_r    <= note_nxt;
      elapsed_r <= elapsed_nxt;
      playing_r <= playing_nxt;
      rep_r     <= rep_nxt;
      cur_len_r <= cur_len_nxt;
      if (p_adv && p_v_r) tone_r <= tone_sel;
      byp_hit_r <= mem_we && (wr_addr == rd_addr);
      if (len_we) len_r[e_mel_r[LEN_IW-1:0]] <= load_len;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready) begin
      e_cmd_r  <= mts_pkg::cmd_t'(in_tuser);
      e_mel_r  <= in_tdata[2:0];
      e_idx_r  <= in_tdata[5:3];
      e_freq_r <= in_tdata[21:6];
      e_dur_r  <= in_tdata[37:22];
      e_rep_r  <= in_tdata[38];
      e_last_r <= in_tlast;
    end
    if (e_adv) begin
      p_act_r     <= act_nxt;
      p_playing_r <= playing_nxt;
      p_note_r    <= note_nxt;
    end
    if (p_adv) begin
      o_tone_r <= tone_sel;
      o_play_r <= p_playing_r;
      o_note_r <= p_note_r;
    end
  end

  // note store, read every cycle at the position the player moves to
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= {e_freq_r, e_dur_r};
    rd_q_r     <= mem[rd_addr];
    byp_data_r <= {e_freq_r, e_dur_r};
  end

  a_rep_needs_play: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r |-> playing_r)
    else $error("repeat flag set while not playing");

  a_play_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    playing_r |-> cur_len_r != '0)
    else $error("playing a melody of length zero");

  a_zero_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (p_v_r && p_act_r == mts_pkg::TONE_ZERO) |-> !p_playing_r)
    else $error("tone silenced while still playing");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (p_v_r && !p_adv) |=> ($stable(note_r) && $stable(elapsed_r) && $stable(cur_mel_r)))
    else $error("player state moved while tone stage stalled");

endmodule

// File: bench/tb_melody_tone_sequencer.sv
// tb_melody_tone_sequencer: self-checking bench for the melody tone sequencer
// drives load/play/stop/tick requests with random gaps and output stalls, predicts
// every tone result in a scoreboard class; depends on rtl/mts_pkg.sv and the block
module tb_melody_tone_sequencer;

  localparam int IDLE_LIMIT   = 1000;
  localparam int PIPE_DEPTH   = 3;
  localparam int RANDOM_ITEMS = 1250;
  localparam int NOTE_COUNT   = mts_pkg::MELODY_SLOTS_DEF * mts_pkg::NOTES_PER_MELODY_DEF;

  typedef struct packed {
    logic [mts_pkg::FREQ_W-1:0] freq;
    logic                       playing;
    logic [mts_pkg::NOTE_W-1:0] pos;
  } tone_t;

  class tone_scoreboard;
    bit [mts_pkg::WORD_W-1:0] notes [NOTE_COUNT];
    bit [mts_pkg::LEN_W-1:0]  mel_len [mts_pkg::MELODY_SLOTS_DEF];
    bit [mts_pkg::MEL_W-1:0]  cur_mel;
    bit [mts_pkg::NOTE_W-1:0] cur_note;
    bit [mts_pkg::DUR_W-1:0]  elapsed;
    bit                       sounding;
    bit                       looping;
    bit [mts_pkg::FREQ_W-1:0] tone;
    bit                       mute;
    tone_t                    tone_due [$];
    int                       fail_count;

    // apply one accepted request to the player and queue the tone it leaves
    function void advance_player(mts_pkg::cmd_t cmd, logic [mts_pkg::IN_TDATA_W-1:0] data,
                                 logic last);
      bit [mts_pkg::MEL_W-1:0]  mel;
      bit [mts_pkg::NOTE_W-1:0] idx;
      bit                       rep;
      int                       nxt;
      mel = data[2:0];
      idx = data[5:3];
      rep = data[38];
      case (cmd)
        mts_pkg::CMD_TICK: begin
          if (sounding) begin
            if (elapsed != '1) elapsed++;
            if (elapsed >= notes[{cur_mel, cur_note}][mts_pkg::DUR_W-1:0]) begin
              nxt = cur_note + 1;
              if ((nxt >= int'(mel_len[cur_mel]) || nxt >= mts_pkg::NOTES_PER_MELODY_DEF)
                  && !looping) begin
                tone = '0;
                sounding = 0;
              end else begin
                if (nxt >= int'(mel_len[cur_mel]) || nxt >= mts_pkg::NOTES_PER_MELODY_DEF)
                  nxt = 0;
                cur_note = nxt[mts_pkg::NOTE_W-1:0];
                elapsed = '0;
                tone = notes[{cur_mel, cur_note}][mts_pkg::WORD_W-1:mts_pkg::DUR_W];
              end
            end
          end
        end
        mts_pkg::CMD_PLAY: begin
          // muted or one-note cut-in over a longer melody, each without repeat, or empty slot: ignored
          if (!(mute && !rep) &&
              !(sounding && mel_len[mel] == 1 && mel_len[cur_mel] > 1 && !rep) &&
              mel_len[mel] != 0) begin
            cur_mel = mel;
            cur_note = '0;
            elapsed = '0;
            sounding = 1;
            looping = rep;
            tone = notes[{mel, 3'd0}][mts_pkg::WORD_W-1:mts_pkg::DUR_W];
          end
        end
        mts_pkg::CMD_STOP: begin
          tone = '0;
          sounding = 0;
          looping = 0;
        end
        mts_pkg::CMD_LOAD: begin
          notes[{mel, idx}] = {data[21:6], data[37:22]};
          if (last) mel_len[mel] = mts_pkg::LEN_W'(idx) + mts_pkg::LEN_W'(1);
        end
        default: begin
        end
      endcase
      tone_due.push_back('{tone, sounding, cur_note});
    endfunction

    function void check_tone(logic [mts_pkg::OUT_TDATA_W-1:0] word);
      tone_t want;
      if (tone_due.size() == 0) begin
        $error("tone result with no request pending: %h", word);
        fail_count++;
      end else begin
        want = tone_due.pop_front();
        if (word[15:0] !== want.freq) begin
          $error("tone_freq expected %0d actual %0d", want.freq, word[15:0]);
          fail_count++;
        end
        if (word[16] !== want.playing) begin
          $error("playing expected %0d actual %0d", want.playing, word[16]);
          fail_count++;
        end
        if (word[19:17] !== want.pos) begin
          $error("note_pos expected %0d actual %0d", want.pos, word[19:17]);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic                            cfg_wdata = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [mts_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]                      in_tuser = mts_pkg::CMD_TICK;
  logic                            in_tlast = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [mts_pkg::OUT_TDATA_W-1:0] out_tdata;

  tone_scoreboard sb = new();
  bit             note_set [NOTE_COUNT];
  bit             in_rush;
  bit             out_rush;
  int             stall_cycles;

  melody_tone_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_tone(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // output backpressure: a fresh random stall, possibly none, before every result, bursts without stalls
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) out_rush = !out_rush;
      stall = out_rush ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  function automatic logic [mts_pkg::IN_TDATA_W-1:0] noise_bits();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return {1'b0, r[mts_pkg::IN_TDATA_W-2:0]};
  endfunction

  task automatic send_req(mts_pkg::cmd_t cmd, logic [mts_pkg::IN_TDATA_W-1:0] data,
                          logic last);
    int gap;
    if ($urandom_range(0, 39) == 0) in_rush = !in_rush;
    gap = in_rush ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.advance_player(cmd, data, last);
  endtask

  // tick, play or stop; fields the command ignores carry noise
  task automatic send_cmd(mts_pkg::cmd_t cmd, bit [mts_pkg::MEL_W-1:0] mel, bit rep);
    logic [mts_pkg::IN_TDATA_W-1:0] data;
    data = noise_bits();
    data[2:0] = mel;
    data[38] = rep;
    send_req(cmd, data, 1'($urandom_range(0, 1)));
  endtask

  // the last flag is dropped unless every lower note of the slot holds data,
  // so a played melody never reaches a note that was never loaded
  task automatic load_note(bit [mts_pkg::MEL_W-1:0] mel, bit [mts_pkg::NOTE_W-1:0] idx,
                           bit [mts_pkg::FREQ_W-1:0] freq, bit [mts_pkg::DUR_W-1:0] dur,
                           bit last);
    int i;
    bit ok;
    ok = 1;
    for (i = 0; i < idx; i++) begin
      if (!note_set[{mel, i[mts_pkg::NOTE_W-1:0]}]) ok = 0;
    end
    note_set[{mel, idx}] = 1;
    send_req(mts_pkg::CMD_LOAD, {1'b0, 1'($urandom_range(0, 1)), dur, freq, idx, mel},
             last && ok);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.tone_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_mute(bit v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.mute = v;
  endtask

  function automatic bit [mts_pkg::FREQ_W-1:0] pick_freq();
    return ($urandom_range(0, 7) == 0) ? '0 : mts_pkg::FREQ_W'($urandom);
  endfunction

  function automatic bit [mts_pkg::MEL_W-1:0] pick_mel();
    return mts_pkg::MEL_W'($urandom_range(0, 7));
  endfunction

  task automatic random_phase(int n);
    int sent;
    int len;
    int pick;
    int i;
    bit [mts_pkg::MEL_W-1:0] mel;
    bit [mts_pkg::DUR_W-1:0] dur;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 2) begin
        // whole melody with mostly short notes, then play it
        mel = pick_mel();
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) begin
          dur = ($urandom_range(0, 15) == 0) ? mts_pkg::DUR_W'($urandom)
                                             : mts_pkg::DUR_W'($urandom_range(0, 4));
          load_note(mel, i[mts_pkg::NOTE_W-1:0], pick_freq(), dur, i == len - 1);
        end
        send_cmd(mts_pkg::CMD_PLAY, mel, 1'($urandom_range(0, 1)));
        sent += len + 1;
      end else begin
        pick = $urandom_range(0, 99);
        sent++;
        if (pick < 60) begin
          send_cmd(mts_pkg::CMD_TICK, pick_mel(), 1'($urandom_range(0, 1)));
        end else if (pick < 78) begin
          send_cmd(mts_pkg::CMD_PLAY, pick_mel(), 1'($urandom_range(0, 1)));
        end else if (pick < 92) begin
          dur = ($urandom_range(0, 7) == 0) ? mts_pkg::DUR_W'($urandom)
                                            : mts_pkg::DUR_W'($urandom_range(0, 6));
          load_note(pick_mel(), mts_pkg::NOTE_W'($urandom_range(0, 7)), pick_freq(), dur,
                    1'($urandom_range(0, 1)));
        end else begin
          send_cmd(mts_pkg::CMD_STOP, pick_mel(), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_mute(1'b0);
    send_cmd(mts_pkg::CMD_TICK, 3'd0, 1'b0);               // tick with nothing playing
    send_cmd(mts_pkg::CMD_PLAY, 3'd0, 1'b0);               // empty melody
    load_note(3'd0, 3'd0, 16'hFFFF, 16'h0000, 1'b0);
    load_note(3'd0, 3'd1, 16'h0000, 16'd1, 1'b1);          // rest note, length 2
    send_cmd(mts_pkg::CMD_PLAY, 3'd0, 1'b0);
    send_cmd(mts_pkg::CMD_TICK, 3'd0, 1'b0);               // zero duration advances at once
    send_cmd(mts_pkg::CMD_TICK, 3'd0, 1'b0);               // end of melody, goes silent
    load_note(3'd1, 3'd0, 16'h1234, 16'd2, 1'b1);
    send_cmd(mts_pkg::CMD_PLAY, 3'd0, 1'b1);
    send_cmd(mts_pkg::CMD_PLAY, 3'd1, 1'b0);               // one-note cut-in, ignored
    repeat (3) send_cmd(mts_pkg::CMD_TICK, 3'd0, 1'b0);    // wraps around
    load_note(3'd0, 3'd0, 16'h8001, 16'd3, 1'b1);          // shrink below current position
    send_cmd(mts_pkg::CMD_TICK, 3'd0, 1'b0);
    load_note(3'd7, 3'd7, 16'hA5A5, 16'hFFFF, 1'b0);
    send_cmd(mts_pkg::CMD_STOP, 3'd0, 1'b0);
    send_cmd(mts_pkg::CMD_PLAY, 3'd1, 1'b1);
    repeat (3) send_cmd(mts_pkg::CMD_TICK, 3'd7, 1'b1);
    send_cmd(mts_pkg::CMD_STOP, 3'd7, 1'b1);
    drain();

    set_mute(1'b1);
    send_cmd(mts_pkg::CMD_PLAY, 3'd0, 1'b0);               // muted
    send_cmd(mts_pkg::CMD_PLAY, 3'd0, 1'b1);               // repeat overrides mute
    send_cmd(mts_pkg::CMD_STOP, 3'd0, 1'b0);
    random_phase(RANDOM_ITEMS / 4);
    drain();
    set_mute(1'b0);
    random_phase(RANDOM_ITEMS / 4);
    drain();
    set_mute(1'b1);
    random_phase(RANDOM_ITEMS / 4);
    drain();
    set_mute(1'b0);
    random_phase(RANDOM_ITEMS / 4);
    drain();

    repeat (PIPE_DEPTH + 2) @(posedge clk);
    if (sb.fail_count == 0 && sb.tone_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
